### design/datins_pkg.sv
// Shared types and constants for the double-array trie insert unit.
// Used by datins_ctrl, datins_dpath and double_array_trie_insert_unit.
package datins_pkg;

   localparam int TABLE_DEPTH  = 4096;
   localparam int MAX_SIBLINGS = 256;
   localparam int AW           = $clog2(TABLE_DEPTH);
   localparam int PW           = AW + 1;
   localparam int LW           = $clog2(MAX_SIBLINGS);
   localparam int NW           = LW + 1;
   localparam int VW           = 32;

   localparam logic [AW-1:0] ROOT_NODE       = AW'(1);
   localparam logic [PW-1:0] PARENT_RESERVED = PW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_INDEX      = AW'(TABLE_DEPTH - 1);
   localparam logic [VW-1:0] NO_VALUE        = '1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_EMPTY,
      OP_RD_BASE,
      OP_CALC_T,
      OP_RD_T,
      OP_CLAIM,
      OP_SCAN_INIT,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_APPEND,
      OP_S_LBL,
      OP_S_PAR,
      OP_S_CHK,
      OP_S_FAIL,
      OP_FIT,
      OP_G_RD,
      OP_G_P,
      OP_G_CHK,
      OP_G_NEXT,
      OP_M_LBL,
      OP_M_RD,
      OP_M_TO,
      OP_M_FROM,
      OP_FIN1,
      OP_FIN2,
      OP_DONE,
      OP_FULL
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rebased;
   } cmd_type;

   typedef struct packed {
      logic zero_code;
      logic t_ok;
      logic par_is_s;
      logic par_zero;
      logic scan_hit;
      logic n_over;
      logic idx_last;
      logic bad;
      logic slot_ok;
      logic k_last;
      logic p_ok;
      logic mv_last;
   } stat_type;

endpackage

### design/datins_ctrl.sv
// Sequencer for the trie insert unit: clear sweep, transition lookup, rebase.
// Depends on datins_pkg; drives datins_dpath through cmd_type.
module datins_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  datins_pkg::stat_type st,
   output datins_pkg::cmd_type  cmd
);
   import datins_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_CALC, S_RDT, S_CHKT, S_DONE0, S_DONE1,
      S_SCAN_RD, S_SCAN_CHK, S_APPEND, S_S_LBL, S_S_PAR, S_S_CHK, S_S_FAIL,
      S_FIT, S_G_RD, S_G_P, S_G_CHK, S_G_NEXT, S_M_INIT, S_M_LBL, S_M_RD,
      S_M_TO, S_M_FROM, S_FIN1, S_FIN2, S_FULL
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.rebased = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (st.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.zero_code) begin
               cmd.op   = OP_EMPTY;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_RD_BASE;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.op   = OP_CALC_T;
            state_in = S_RDT;
         end
         S_RDT: begin
            if (st.t_ok) begin
               cmd.op   = OP_RD_T;
               state_in = S_CHKT;
            end else begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SCAN_RD;
            end
         end
         S_CHKT: begin
            if (st.par_is_s) begin
               state_in = S_DONE0;
            end else if (st.par_zero) begin
               cmd.op   = OP_CLAIM;
               state_in = S_DONE0;
            end else begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SCAN_RD;
            end
         end
         S_DONE0: begin
            cmd.op   = OP_DONE;
            state_in = S_IDLE;
         end
         S_DONE1: begin
            cmd.op      = OP_DONE;
            cmd.rebased = 1'b1;
            state_in    = S_IDLE;
         end
         S_SCAN_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.op = OP_SCAN_CHK;
            if (st.scan_hit && st.n_over) state_in = S_FULL;
            else if (st.idx_last)         state_in = S_APPEND;
            else                          state_in = S_SCAN_RD;
         end
         S_APPEND: begin
            cmd.op   = OP_APPEND;
            state_in = st.bad ? S_FULL : S_S_LBL;
         end
         S_S_LBL: begin
            cmd.op   = OP_S_LBL;
            state_in = S_S_PAR;
         end
         S_S_PAR: begin
            cmd.op   = OP_S_PAR;
            state_in = st.slot_ok ? S_S_CHK : S_S_FAIL;
         end
         S_S_CHK: begin
            cmd.op = OP_S_CHK;
            if (!st.par_zero)   state_in = S_S_FAIL;
            else if (st.k_last) state_in = S_FIT;
            else                state_in = S_S_LBL;
         end
         S_S_FAIL: begin
            cmd.op   = OP_S_FAIL;
            state_in = st.idx_last ? S_FULL : S_S_LBL;
         end
         S_FIT: begin
            cmd.op   = OP_FIT;
            state_in = S_G_RD;
         end
         S_G_RD: begin
            cmd.op   = OP_G_RD;
            state_in = S_G_P;
         end
         S_G_P: begin
            cmd.op   = OP_G_P;
            state_in = st.p_ok ? S_G_CHK : S_G_NEXT;
         end
         S_G_CHK: begin
            cmd.op   = OP_G_CHK;
            state_in = st.idx_last ? S_M_INIT : S_G_RD;
         end
         S_G_NEXT: begin
            cmd.op   = OP_G_NEXT;
            state_in = st.idx_last ? S_M_INIT : S_G_RD;
         end
         S_M_INIT: begin
            // only the new code in the label list: nothing to move
            state_in = st.k_last ? S_FIN1 : S_M_LBL;
         end
         S_M_LBL: begin
            cmd.op   = OP_M_LBL;
            state_in = S_M_RD;
         end
         S_M_RD: begin
            cmd.op   = OP_M_RD;
            state_in = S_M_TO;
         end
         S_M_TO: begin
            cmd.op   = OP_M_TO;
            state_in = S_M_FROM;
         end
         S_M_FROM: begin
            cmd.op   = OP_M_FROM;
            state_in = st.mv_last ? S_FIN1 : S_M_LBL;
         end
         S_FIN1: begin
            cmd.op   = OP_FIN1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            cmd.op   = OP_FIN2;
            state_in = S_DONE1;
         end
         S_FULL: begin
            cmd.op   = OP_FULL;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/datins_dpath.sv
// Datapath of the trie insert unit: base, parent, value and label memories,
// scan counters and the result register. Depends on datins_pkg.
module datins_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  datins_pkg::cmd_type     cmd,
   output datins_pkg::stat_type    st,
   input  logic [7:0]              req_code,
   input  logic                    req_last_code,
   input  logic [30:0]             req_key_value,
   output logic                    rsp_strobe,
   output logic [datins_pkg::AW-1:0] rsp_node_index,
   output logic                    rsp_status,
   output logic                    rsp_rebased
);
   import datins_pkg::*;

   logic [AW-1:0] base_mem [TABLE_DEPTH];
   logic [PW-1:0] par_mem  [TABLE_DEPTH];
   logic [VW-1:0] val_mem  [TABLE_DEPTH];
   logic [AW-1:0] lbl_mem  [MAX_SIBLINGS];

   logic [AW-1:0] base_rd_ff;
   logic [PW-1:0] par_rd_ff;
   logic [VW-1:0] val_rd_ff;
   logic [AW-1:0] lbl_rd_ff;

   logic [7:0]    code_ff;
   logic          last_ff;
   logic [30:0]   kval_ff;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] ob_ff;
   logic [PW-1:0] t_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] nb_ff;
   logic [NW-1:0] k_ff;
   logic [NW-1:0] n_ff;
   logic          bad_ff;
   logic [PW-1:0] p_ff;
   logic [AW-1:0] lbl_ff;
   logic          strobe_ff, strobe_in;
   logic [AW-1:0] node_ff;
   logic          status_ff;
   logic          rebased_ff;

   logic [AW-1:0] base_ra, base_wa, base_wd;
   logic          base_we;
   logic [AW-1:0] par_ra, par_wa;
   logic [PW-1:0] par_wd;
   logic          par_we;
   logic [AW-1:0] val_ra, val_wa;
   logic [VW-1:0] val_wd;
   logic          val_we;
   logic [LW-1:0] lbl_ra, lbl_wa;
   logic [AW-1:0] lbl_wd;
   logic          lbl_we;

   logic [PW-1:0] cursor_x;
   logic [PW-1:0] slot;
   logic [AW-1:0] from_rd, from_ff, to_ff;

   assign cursor_x = {1'b0, cursor_ff};
   assign slot     = {1'b0, idx_ff} + {1'b0, lbl_rd_ff};
   assign from_rd  = ob_ff + lbl_rd_ff;
   assign from_ff  = ob_ff + lbl_ff;
   assign to_ff    = nb_ff + lbl_ff;

   always_comb begin
      st.zero_code = (code_ff == 8'd0);
      st.t_ok      = ~t_ff[PW-1];
      st.par_is_s  = (par_rd_ff == cursor_x);
      st.par_zero  = (par_rd_ff == '0);
      st.scan_hit  = (par_rd_ff == cursor_x);
      st.n_over    = (n_ff >= NW'(MAX_SIBLINGS - 1));
      st.idx_last  = (idx_ff == LAST_INDEX);
      st.bad       = bad_ff;
      st.slot_ok   = ~slot[PW-1];
      st.k_last    = ((k_ff + NW'(1)) == n_ff);
      st.p_ok      = (par_rd_ff != '0) && (par_rd_ff != cursor_x) && ~par_rd_ff[PW-1];
      // the new code sits last in the label list and is never moved
      st.mv_last   = ((k_ff + NW'(2)) == n_ff);
   end

   // memory port steering
   always_comb begin
      base_ra = cursor_ff;
      par_ra  = idx_ff;
      val_ra  = from_rd;
      lbl_ra  = k_ff[LW-1:0];
      base_we = 1'b0; base_wa = idx_ff; base_wd = '0;
      par_we  = 1'b0; par_wa  = idx_ff; par_wd  = '0;
      val_we  = 1'b0; val_wa  = t_ff[AW-1:0]; val_wd = {1'b0, kval_ff};
      lbl_we  = 1'b0; lbl_wa  = n_ff[LW-1:0]; lbl_wd = idx_ff - ob_ff;
      case (cmd.op)
         OP_CLEAR: begin
            base_we = 1'b1;
            par_we  = 1'b1;
            val_we  = 1'b1;
            val_wa  = idx_ff;
            val_wd  = NO_VALUE;
            base_wd = (idx_ff == ROOT_NODE) ? AW'(1) : '0;
            par_wd  = (idx_ff == ROOT_NODE) ? PARENT_RESERVED : '0;
         end
         OP_EMPTY: begin
            val_we = last_ff;
            val_wa = ROOT_NODE;
         end
         OP_RD_T:  par_ra = t_ff[AW-1:0];
         OP_CLAIM, OP_FIN2: begin
            par_we  = 1'b1; par_wa  = t_ff[AW-1:0]; par_wd = cursor_x;
            base_we = 1'b1; base_wa = t_ff[AW-1:0]; base_wd = AW'(1);
         end
         OP_SCAN_CHK: lbl_we = st.scan_hit && !st.n_over;
         OP_APPEND: begin
            lbl_we = 1'b1;
            lbl_wd = AW'(code_ff);
         end
         OP_S_PAR: par_ra = slot[AW-1:0];
         OP_G_P:   par_ra = par_rd_ff[AW-1:0];
         OP_G_CHK: begin
            par_we = st.par_is_s;
            par_wd = {1'b0, nb_ff + (p_ff[AW-1:0] - ob_ff)};
         end
         OP_M_RD:  base_ra = from_rd;
         OP_M_TO: begin
            base_we = 1'b1; base_wa = to_ff; base_wd = base_rd_ff;
            val_we  = 1'b1; val_wa  = to_ff; val_wd  = val_rd_ff;
            par_we  = 1'b1; par_wa  = to_ff; par_wd  = cursor_x;
         end
         OP_M_FROM: begin
            base_we = 1'b1; base_wa = from_ff; base_wd = '0;
            val_we  = 1'b1; val_wa  = from_ff; val_wd  = NO_VALUE;
            par_we  = 1'b1; par_wa  = from_ff; par_wd  = '0;
         end
         OP_FIN1: begin
            base_we = 1'b1; base_wa = cursor_ff; base_wd = nb_ff;
         end
         OP_DONE: val_we = last_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (base_we) base_mem[base_wa] <= base_wd;
      base_rd_ff <= base_mem[base_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_rd_ff <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      val_rd_ff <= val_mem[val_ra];
   end

   always_ff @(posedge clock) begin
      if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
      lbl_rd_ff <= lbl_mem[lbl_ra];
   end

   always_comb begin
      idx_in    = idx_ff;
      cursor_in = cursor_ff;
      strobe_in = 1'b0;
      case (cmd.op)
         OP_CLEAR, OP_SCAN_CHK, OP_S_FAIL, OP_G_CHK, OP_G_NEXT:
            idx_in = idx_ff + AW'(1);
         OP_SCAN_INIT, OP_FIT:
            idx_in = AW'(1);
         OP_APPEND:
            idx_in = AW'(1);
         OP_EMPTY: begin
            strobe_in = 1'b1;
            if (last_ff) cursor_in = ROOT_NODE;
         end
         OP_DONE: begin
            strobe_in = 1'b1;
            cursor_in = last_ff ? ROOT_NODE : t_ff[AW-1:0];
         end
         OP_FULL: begin
            strobe_in = 1'b1;
            cursor_in = ROOT_NODE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         cursor_ff <= ROOT_NODE;
         strobe_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         cursor_ff <= cursor_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            code_ff <= req_code;
            last_ff <= req_last_code;
            kval_ff <= req_key_value;
         end
         OP_CALC_T: begin
            ob_ff <= base_rd_ff;
            t_ff  <= {1'b0, base_rd_ff} + PW'(code_ff);
         end
         OP_SCAN_INIT: begin
            n_ff   <= '0;
            bad_ff <= 1'b0;
         end
         OP_SCAN_CHK: begin
            if (st.scan_hit && !st.n_over) begin
               n_ff <= n_ff + NW'(1);
               if (idx_ff < ob_ff) bad_ff <= 1'b1;
            end
         end
         OP_APPEND: begin
            n_ff <= n_ff + NW'(1);
            k_ff <= '0;
         end
         OP_S_CHK: k_ff <= k_ff + NW'(1);
         OP_S_FAIL: k_ff <= '0;
         OP_FIT: begin
            nb_ff <= idx_ff;
            k_ff  <= '0;
         end
         OP_G_P: p_ff <= par_rd_ff;
         OP_M_RD: lbl_ff <= lbl_rd_ff;
         OP_M_FROM: k_ff <= k_ff + NW'(1);
         OP_FIN1: t_ff <= {1'b0, nb_ff} + PW'(code_ff);
         OP_EMPTY: begin
            node_ff    <= last_ff ? ROOT_NODE : cursor_ff;
            status_ff  <= 1'b0;
            rebased_ff <= 1'b0;
         end
         OP_DONE: begin
            node_ff    <= t_ff[AW-1:0];
            status_ff  <= 1'b0;
            rebased_ff <= cmd.rebased;
         end
         OP_FULL: begin
            node_ff    <= '0;
            status_ff  <= 1'b1;
            rebased_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_node_index = node_ff;
   assign rsp_status     = status_ff;
   assign rsp_rebased    = rebased_ff;

endmodule

### design/double_array_trie_insert_unit.sv
// Double-array trie insert unit, top level.
// Depends on datins_pkg, datins_ctrl and datins_dpath.
//
// Feeds one key code per request: pulse start while busy is low. Each request
// returns exactly one result, shown for a single cycle with rsp_strobe; the
// receiver cannot stall it, so capture it when the strobe is high. After reset
// the unit sweeps its 4096-entry base, parent and value memories, one entry a
// cycle, and holds busy high during the sweep. A zero code is answered from the
// decode state; a code that follows or claims a transition passes through the
// chained reads of the base and parent memories, and its result is registered
// before rsp_strobe shows it. A rebase runs through the single parent read port:
// a scan to collect children, label read, parent read and check for each label
// at each candidate base plus a step past each rejected base, a scan to repair
// grandchild links, and label read, read, write and clear for each moved child.
module double_array_trie_insert_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [7:0]              req_code,
   input  logic                    req_last_code,
   input  logic [30:0]             req_key_value,
   output logic                    rsp_strobe,
   output logic [datins_pkg::AW-1:0] rsp_node_index,
   output logic                    rsp_status,
   output logic                    rsp_rebased
);
   import datins_pkg::*;

   cmd_type  cmd;
   stat_type st;

   datins_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   datins_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_code       (req_code),
      .req_last_code  (req_last_code),
      .req_key_value  (req_key_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_node_index (rsp_node_index),
      .rsp_status     (rsp_status),
      .rsp_rebased    (rsp_rebased)
   );

endmodule
